@@ hdl/tmvc_pkg.sv @@
// tmvc_pkg: shared types and constants of the text mode video card.
// Item and result structs, command codes, controller/datapath interface.
// No dependencies.
package tmvc_pkg;

    localparam int TEXT_AW   = 11;
    localparam int FONT_AW   = 12;
    localparam int REG_AW    = 6;
    localparam int COLUMNS   = 80;
    localparam int DIV_SHIFT = 14;

    localparam logic [15:0] CTRL_ADDR   = 16'hD5F6;
    localparam logic [7:0]  WINDOW_PAGE = 8'hD6;
    localparam logic [7:0]  REG_ID_ADDR = 8'h3A;
    localparam logic [7:0]  REG_ID_VAL  = 8'h01;
    localparam logic [7:0]  OPEN_BUS    = 8'hFF;

    localparam logic [REG_AW-1:0] REG_START0_LO = 6'h0C;
    localparam logic [REG_AW-1:0] REG_START0_HI = 6'h0D;
    localparam logic [REG_AW-1:0] REG_START1_LO = 6'h0E;
    localparam logic [REG_AW-1:0] REG_START1_HI = 6'h0F;
    localparam logic [REG_AW-1:0] REG_SPLIT_ROW = 6'h10;
    localparam logic [REG_AW-1:0] REG_CURS_ROW  = 6'h18;
    localparam logic [REG_AW-1:0] REG_CURS_COL  = 6'h19;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FONT  = 2'd2,
        CMD_PIXEL = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  data;
        logic [11:0] font_address;
        logic [8:0]  scanline;
        logic [6:0]  column;
        logic        blink;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pixels;
        logic [3:0] colour;
    } result_t;

    typedef struct packed {
        logic clear_en;
        logic load_item;
        logic do_write;
        logic text_rd;
        logic div_mul;
        logic div_sub;
        logic div_fix;
        logic pos_calc;
        logic font_rd;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic clear_done;
    } status_t;

endpackage

@@ hdl/tmvc_ctrl.sv @@
// tmvc_ctrl: sequencer of the text mode video card.
// Steps each item through the datapath and owns the result valid flag.
// Depends on tmvc_pkg.
module tmvc_ctrl
    import tmvc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] item_command,
    input  logic       result_ready,
    output logic       result_valid,
    output ctrl_t      ctrl,
    input  status_t    status
);

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_WRITE = 11'b000_0000_0100,
        ST_READ  = 11'b000_0000_1000,
        ST_MUL   = 11'b000_0001_0000,
        ST_DIV   = 11'b000_0010_0000,
        ST_FIX   = 11'b000_0100_0000,
        ST_POS   = 11'b000_1000_0000,
        ST_TEXT  = 11'b001_0000_0000,
        ST_FONT  = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_en = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl.load_item = 1'b1;
                    unique case (item_command) inside
                        CMD_WRITE, CMD_FONT: state_next = ST_WRITE;
                        CMD_READ:            state_next = ST_READ;
                        CMD_PIXEL:           state_next = ST_MUL;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                ctrl.do_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_READ:
            begin
                ctrl.text_rd = 1'b1;
                state_next   = ST_DONE;
            end
            ST_MUL:
            begin
                ctrl.div_mul = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                ctrl.div_sub = 1'b1;
                state_next   = ST_FIX;
            end
            ST_FIX:
            begin
                ctrl.div_fix = 1'b1;
                state_next   = ST_POS;
            end
            ST_POS:
            begin
                ctrl.pos_calc = 1'b1;
                state_next    = ST_TEXT;
            end
            ST_TEXT:
            begin
                ctrl.text_rd = 1'b1;
                state_next   = ST_FONT;
            end
            ST_FONT:
            begin
                ctrl.font_rd = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !ctrl.load_out)
        else $error("result overwritten while stalled");

    a_pixel_start: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_command == CMD_PIXEL) |=> state_reg == ST_MUL)
        else $error("pixel fetch did not start the divide");

    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && status.clear_done)
            |=> (state_reg == ST_IDLE && !out_valid_reg))
        else $error("clearing pass did not end cleanly");
`endif

endmodule

@@ hdl/tmvc_datapath.sv @@
// tmvc_datapath: stores, window decode, row divide and pixel shading.
// Driven by the command struct from tmvc_ctrl.
// Depends on tmvc_pkg.
module tmvc_datapath
    import tmvc_pkg::*;
#(
    parameter int ROWS        = 25,
    parameter int CELL_HEIGHT = 10
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  ctrl_t   ctrl,
    output status_t status,
    output result_t result
);

    localparam logic [4:0]  CH        = 5'(CELL_HEIGHT);
    localparam logic [4:0]  LAST_LINE = 5'(CELL_HEIGHT - 1);
    localparam logic [14:0] RECIP     = 15'((1 << DIV_SHIFT) / CELL_HEIGHT);
    localparam logic [8:0]  ROW_LIMIT = 9'(ROWS);

    logic [7:0] char_mem [2**TEXT_AW];
    logic [7:0] attr_mem [2**TEXT_AW];
    logic [7:0] font_mem [2**FONT_AW];
    logic [7:0] regs_mem [2**REG_AW];

    // control and display register copies
    logic [TEXT_AW-1:0] clear_cnt_reg;
    logic               char_off_reg, attr_off_reg, regs_off_reg;
    logic [3:0]         bank_reg;
    logic [13:0]        start0_reg, start1_reg;
    logic [7:0]         split_row_reg, curs_row_reg, curs_col_reg;

    // item and datapath payload
    item_t              item_reg;
    logic [23:0]        prod_reg;
    logic [8:0]         quot_reg;
    logic [5:0]         rem_reg;
    logic [8:0]         row_reg;
    logic [3:0]         line_reg;
    logic [TEXT_AW-1:0] pos_reg;
    logic [7:0]         char_rd_reg, attr_rd_reg, regs_rd_reg, font_rd_reg;
    result_t            result_reg, result_next;

    logic               page_hit, regs_hit, ctrl_hit, is_write, win_write;
    logic [TEXT_AW-1:0] win_idx, text_wa, text_ra;
    logic [7:0]         text_wd;
    logic [REG_AW-1:0]  regs_wa;
    logic               char_we, attr_we, regs_we, font_we, reg_upd;
    logic [FONT_AW-1:0] font_ra;
    logic [8:0]         quot_est;
    logic [13:0]        qmul, rem_full;
    logic               lower_part;
    logic [8:0]         rel_row;
    logic [15:0]        rel_mul;
    logic [13:0]        start_sel;
    logic [7:0]         rd_byte, shade;
    logic               blank, cursor_hit;

    assign page_hit  = (item_reg.address[15:8] == WINDOW_PAGE);
    assign ctrl_hit  = (item_reg.address == CTRL_ADDR);
    assign regs_hit  = !regs_off_reg && (bank_reg == 4'd0) && (item_reg.address[7:6] == 2'b00);
    assign is_write  = (item_reg.command == CMD_WRITE);
    assign win_write = ctrl.do_write && is_write && page_hit;
    assign win_idx   = {bank_reg, item_reg.address[6:0]};

    assign char_we = ctrl.clear_en || (win_write && !char_off_reg);
    assign attr_we = ctrl.clear_en || (win_write && char_off_reg && !attr_off_reg);
    assign reg_upd = win_write && char_off_reg && attr_off_reg && regs_hit;
    assign regs_we = ctrl.clear_en || reg_upd;
    assign font_we = ctrl.do_write && (item_reg.command == CMD_FONT);

    assign text_wa = ctrl.clear_en ? clear_cnt_reg : win_idx;
    assign text_wd = ctrl.clear_en ? 8'h00 : item_reg.data;
    assign regs_wa = ctrl.clear_en ? clear_cnt_reg[REG_AW-1:0] : item_reg.address[REG_AW-1:0];
    assign text_ra = (item_reg.command == CMD_PIXEL) ? pos_reg : win_idx;
    assign font_ra = {char_rd_reg, line_reg};

    assign status.clear_done = ctrl.clear_en && (clear_cnt_reg == '1);

    // row = scanline / CELL_HEIGHT by reciprocal, one correction step
    assign quot_est = prod_reg[DIV_SHIFT+8:DIV_SHIFT];
    assign qmul     = 14'(quot_est) * 14'(CH);
    assign rem_full = 14'(item_reg.scanline) - qmul;

    assign lower_part = (row_reg >= 9'(split_row_reg));
    assign rel_row    = lower_part ? (row_reg - 9'(split_row_reg)) : row_reg;
    assign rel_mul    = 16'(rel_row) * 16'(COLUMNS);
    assign start_sel  = lower_part ? start1_reg : start0_reg;

    always_comb
    begin
        if (!page_hit)
        begin
            rd_byte = OPEN_BUS;
        end
        else if (!char_off_reg)
        begin
            rd_byte = char_rd_reg;
        end
        else if (!attr_off_reg)
        begin
            rd_byte = attr_rd_reg;
        end
        else if (regs_hit)
        begin
            rd_byte = (item_reg.address[7:0] == REG_ID_ADDR) ? REG_ID_VAL : regs_rd_reg;
        end
        else
        begin
            rd_byte = OPEN_BUS;
        end
    end

    assign blank      = (row_reg >= ROW_LIMIT);
    assign cursor_hit = (row_reg == 9'(curs_row_reg)) && (8'(item_reg.column) == curs_col_reg)
                        && !item_reg.blink;

    always_comb
    begin
        shade = font_rd_reg;
        if (attr_rd_reg[0])
        begin
            shade = ~shade;
        end
        if (attr_rd_reg[1] && item_reg.blink)
        begin
            shade = 8'h00;
        end
        if ((5'(line_reg) == LAST_LINE) && attr_rd_reg[2])
        begin
            shade = 8'hFF;
        end
        if (cursor_hit)
        begin
            shade = 8'hFF;
        end
    end

    always_comb
    begin
        result_next = '0;
        unique case (item_reg.command)
            CMD_READ:
            begin
                result_next.read_data = rd_byte;
            end
            CMD_PIXEL:
            begin
                if (!blank)
                begin
                    result_next.pixels = shade;
                    result_next.colour = attr_rd_reg[7:4];
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            char_off_reg  <= 1'b0;
            attr_off_reg  <= 1'b0;
            regs_off_reg  <= 1'b0;
            bank_reg      <= 4'd0;
            start0_reg    <= '0;
            start1_reg    <= '0;
            split_row_reg <= '0;
            curs_row_reg  <= '0;
            curs_col_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear_en)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (ctrl.do_write && is_write && ctrl_hit)
            begin
                char_off_reg <= item_reg.data[4];
                attr_off_reg <= item_reg.data[5];
                regs_off_reg <= item_reg.data[6];
                bank_reg     <= item_reg.data[3:0];
            end
            if (reg_upd)
            begin
                unique case (item_reg.address[REG_AW-1:0])
                    REG_START0_LO: start0_reg[7:0]  <= item_reg.data;
                    REG_START0_HI: start0_reg[13:8] <= item_reg.data[5:0];
                    REG_START1_LO: start1_reg[7:0]  <= item_reg.data;
                    REG_START1_HI: start1_reg[13:8] <= item_reg.data[5:0];
                    REG_SPLIT_ROW: split_row_reg    <= item_reg.data;
                    REG_CURS_ROW:  curs_row_reg     <= item_reg.data;
                    REG_CURS_COL:  curs_col_reg     <= item_reg.data;
                    default:       curs_col_reg     <= curs_col_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= item;
        end
        if (ctrl.div_mul)
        begin
            prod_reg <= 24'(item_reg.scanline) * 24'(RECIP);
        end
        if (ctrl.div_sub)
        begin
            quot_reg <= quot_est;
            rem_reg  <= rem_full[5:0];
        end
        if (ctrl.div_fix)
        begin
            if (rem_reg >= 6'(CH))
            begin
                row_reg  <= quot_reg + 9'd1;
                line_reg <= 4'(rem_reg - 6'(CH));
            end
            else
            begin
                row_reg  <= quot_reg;
                line_reg <= rem_reg[3:0];
            end
        end
        if (ctrl.pos_calc)
        begin
            pos_reg <= rel_mul[TEXT_AW-1:0] + TEXT_AW'(item_reg.column)
                       + start_sel[TEXT_AW-1:0];
        end
        if (ctrl.load_out)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[text_wa] <= text_wd;
        end
        if (ctrl.text_rd)
        begin
            char_rd_reg <= char_mem[text_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[text_wa] <= text_wd;
        end
        if (ctrl.text_rd)
        begin
            attr_rd_reg <= attr_mem[text_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (regs_we)
        begin
            regs_mem[regs_wa] <= text_wd;
        end
        if (ctrl.text_rd)
        begin
            regs_rd_reg <= regs_mem[item_reg.address[REG_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[item_reg.font_address] <= item_reg.data;
        end
        if (ctrl.font_rd)
        begin
            font_rd_reg <= font_mem[font_ra];
        end
    end

`ifndef ASSERT_OFF
    a_divide: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pos_calc |-> ((14'(row_reg) * 14'(CH) + 14'(line_reg) == 14'(item_reg.scanline))
                           && (5'(line_reg) < CH)))
        else $error("row/line split of scanline wrong");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load_out && item_reg.command != CMD_READ) |=> (result_reg.read_data == 8'h00))
        else $error("read_data not zero for non-read item");

    a_blank_row: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load_out && item_reg.command == CMD_PIXEL && row_reg >= ROW_LIMIT)
            |=> (result_reg.pixels == 8'h00 && result_reg.colour == 4'h0))
        else $error("row past screen not blanked");
`endif

endmodule

@@ hdl/text_mode_video_card.sv @@
// text_mode_video_card: top level, 80-column text card.
// Joins tmvc_ctrl and tmvc_datapath. Depends on tmvc_pkg.
//
// Usage:
//   item channel (item_valid/item_ready/item): bus write, bus read, font
//   load or pixel fetch; accepted when valid and ready are both high.
//   result channel (result_valid/result_ready/result): one result per item,
//   in order; read_data, pixels and colour are zero where not meaningful.
// Sequence:
//   One item is in flight at a time. Bus write, bus read and font load
//   go through their write or read step and the result load, a pixel
//   fetch through reciprocal divide of the scanline (multiply, subtract,
//   correct), position add, screen and attribute read, font read, result
//   load. The single read port of each store sets the sequence.
//   The result register frees the input side: the next item is taken
//   while a result still waits; a held result stalls only the final step.
// Reset:
//   rst_n clears control state, then a clearing pass over every screen
//   address zeroes the screen, attribute and display register stores;
//   item_ready stays low until it ends. The font store is not cleared.
module text_mode_video_card
    import tmvc_pkg::*;
#(
    parameter int ROWS        = 25,
    parameter int CELL_HEIGHT = 10
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    ctrl_t   ctrl;
    status_t status;

    tmvc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_command (item.command),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .ctrl         (ctrl),
        .status       (status)
    );

    tmvc_datapath #(
        .ROWS        (ROWS),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctrl   (ctrl),
        .status (status),
        .result (result)
    );

endmodule
